>>> rtl/rieu_pkg.sv
// ----------------------------------------------------------------------------
// rieu_pkg
// Shared types and constants for the integer execute unit.
// ----------------------------------------------------------------------------
package rieu_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int CNT_WORDS = 1024;
    localparam int CNT_AW    = $clog2(CNT_WORDS);
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int CLR_WORDS = (MEM_WORDS > CNT_WORDS) ? MEM_WORDS : CNT_WORDS;
    localparam int CLR_AW    = $clog2(CLR_WORDS);

    localparam int IN_W  = 72;
    localparam int OUT_W = 144;

    localparam logic [REG_AW-1:0] REG_QUO  = REG_AW'(24);
    localparam logic [REG_AW-1:0] REG_REM  = REG_AW'(25);
    localparam logic [REG_AW-1:0] REG_LINK = REG_AW'(31);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_DIVZ  = 2'd2;
    localparam logic [1:0] ST_UNIMP = 2'd3;

    typedef enum logic [6:0] {
        OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW,
        OP_ADDI, OP_ADDUI, OP_SUBI, OP_SUBUI,
        OP_SEQI, OP_SEQUI, OP_SNEI, OP_SNEUI, OP_SLTI, OP_SLTUI, OP_SGTI, OP_SGTUI,
        OP_SLEI, OP_SLEUI, OP_SGEI, OP_SGEUI,
        OP_ANDI, OP_ORI, OP_XORI, OP_LHI,
        OP_ADD, OP_ADDU, OP_SUB, OP_SUBU,
        OP_SEQ, OP_SNE, OP_SLT, OP_SLTU, OP_SGT, OP_SGTU, OP_SLE, OP_SLEU,
        OP_SGE, OP_SGEU,
        OP_AND, OP_OR, OP_XOR, OP_NOP,
        OP_SLL, OP_SRL, OP_SRA, OP_SLLI, OP_SRLI, OP_SRAI,
        OP_MULT, OP_MULTU, OP_DIV, OP_DIVU, OP_MVTS, OP_MVFS,
        OP_J, OP_JAL, OP_JR, OP_JALR, OP_BEQZ, OP_BNEZ, OP_SELECT,
        OP_TRAP, OP_RFE, OP_BREAK, OP_HALT, OP_PCOUNT
    } t_op;

    typedef struct packed {
        logic start;
        logic sgn;
    } t_div_ctl;

endpackage

>>> rtl/rieu_div.sv
// ----------------------------------------------------------------------------
// rieu_div
// Radix-2 restoring divider, one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
module rieu_div
    import rieu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_ctl    i_ctl,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);

    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        r_negq;
    logic        r_negr;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        na;
    logic        nb;

    assign na     = i_ctl.sgn & i_a[31];
    assign nb     = i_ctl.sgn & i_b[31];
    assign rem_sh = {r_rem[31:0], r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_ctl.start && (r_cnt == 6'd31);
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= na ? (32'd0 - i_a) : i_a;
                r_den  <= nb ? (32'd0 - i_b) : i_b;
                r_negq <= na ^ nb;
                r_negr <= na;
            end else if (r_busy) begin
                if (!diff[32]) begin
                    r_rem <= diff;
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_negq ? (32'd0 - r_quo) : r_quo;
    assign o_rem  = r_negr ? (32'd0 - r_rem[31:0]) : r_rem[31:0];

endmodule

>>> rtl/risc_integer_execute_unit_core.sv
// ----------------------------------------------------------------------------
// risc_integer_execute_unit_core
// Sequenced integer execute unit with register file, data memory and
// profile counters.
//
//  channel | dir | fields
//  s_axis  | in  | cmd, src_reg, second_reg, dest_reg, select_false_reg,
//          |     | immediate, jump_offset
//  m_axis  | out | status, next_pc, reg_written, written_index,
//          |     | written_value, remainder_written, remainder_value,
//          |     | counter_value
//
// An item passes S_IDLE, S_RA, S_RB, S_RC and S_EX; memory and pcount items
// then pass S_M1 and S_M2, nonzero divides wait in S_DV on the bit-serial
// divider; all end in S_FIN, plus S_R25 when the remainder goes to r25, then
// S_OUT. Items taken while halted go straight to S_OUT. The unit is back in
// S_IDLE after each result is taken. After reset a clear pass over
// max(MEM_WORDS, CNT_WORDS) addresses zeroes the memories and register file;
// no item is accepted meanwhile. One item is in flight at a time; a stalled result holds the unit.
// ----------------------------------------------------------------------------
module risc_integer_execute_unit_core
    import rieu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // cmd[6:0] src_reg[11:7] second_reg[16:12] dest_reg[21:17]
    // select_false_reg[26:22] immediate[42:27] jump_offset[68:43]
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // status[1:0] next_pc[33:2] reg_written[34] written_index[39:35]
    // written_value[71:40] remainder_written[72] remainder_value[104:73]
    // counter_value[136:105]
    output logic [OUT_W-1:0]  m_axis_tdata
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RA, S_RB, S_RC, S_EX, S_M1, S_M2, S_DV, S_FIN, S_R25, S_OUT
    } t_state;

    t_state r_state;
    t_state ex_next;

    logic [31:0] r_rf [REG_COUNT];
    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_cmem [CNT_WORDS];
    logic [31:0] r_rf_q;
    logic [31:0] r_mem_q;
    logic [31:0] r_cnt_q;

    logic [CLR_AW-1:0] r_clr;
    logic [6:0]  r_cmd;
    logic [4:0]  r_rs, r_rt, r_rd, r_rsel;
    logic [31:0] r_simm;
    logic [31:0] r_off;
    logic [31:0] r_a, r_b;
    logic [31:0] r_pc;
    logic [31:0] r_npc;
    logic [31:0] r_addr;
    logic        r_halted;
    logic [CNT_AW-1:0] r_hi_cnt;
    logic [1:0]  r_status;
    logic        r_wr;
    logic [4:0]  r_dst;
    logic [31:0] r_val;
    logic        r_remw;
    logic [31:0] r_remv;
    logic [31:0] r_cntv;

    logic [4:0]  rf_raddr;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic        me_we;
    logic [MEM_AW-1:0] me_addr;
    logic [31:0] me_wdata;
    logic        ce_we;
    logic [CNT_AW-1:0] ce_addr;
    logic [31:0] ce_wdata;

    t_div_ctl    div_ctl;
    logic        div_done;
    logic [31:0] div_q, div_r;

    t_op         op;
    logic [31:0] uimm;
    logic [31:0] pc4;
    logic [31:0] ex_npc;
    logic [31:0] cmp_b;
    logic        eq, lt, ltu, gt, gtu;
    logic [31:0] cmp_v;
    logic [31:0] ld_byte, ld_half, st_word;
    logic [CNT_AW-1:0] cidx;
    logic [31:0] cnt_new;
    logic        clr_mem, clr_cnt, clr_rf;

    assign op   = t_op'(r_cmd);
    assign uimm = {16'd0, r_simm[15:0]};
    assign pc4  = r_pc + 32'd4;
    assign cidx = r_simm[CNT_AW-1:0];

    always_comb begin
        case (op)
            OP_SEQI, OP_SEQUI, OP_SNEI, OP_SNEUI, OP_SLTI, OP_SLTUI, OP_SGTI,
            OP_SGTUI, OP_SLEI, OP_SLEUI, OP_SGEI, OP_SGEUI: cmp_b = r_simm;
            default: cmp_b = r_b;
        endcase
        eq  = (r_a == cmp_b);
        ltu = (r_a < cmp_b);
        gtu = (cmp_b < r_a);
        lt  = ($signed(r_a) < $signed(cmp_b));
        gt  = ($signed(cmp_b) < $signed(r_a));
        case (op)
            OP_SEQI, OP_SEQUI, OP_SEQ:  cmp_v = {31'd0, eq};
            OP_SNEI, OP_SNEUI, OP_SNE:  cmp_v = {31'd0, !eq};
            OP_SLTI, OP_SLT:            cmp_v = {31'd0, lt};
            OP_SLTUI, OP_SLTU:          cmp_v = {31'd0, ltu};
            OP_SGTI, OP_SGT:            cmp_v = {31'd0, gt};
            OP_SGTUI, OP_SGTU:          cmp_v = {31'd0, gtu};
            OP_SLEI, OP_SLE:            cmp_v = {31'd0, !gt};
            OP_SLEUI, OP_SLEU:          cmp_v = {31'd0, !gtu};
            OP_SGEI, OP_SGE:            cmp_v = {31'd0, !lt};
            default:                    cmp_v = {31'd0, !ltu};
        endcase
    end

    always_comb begin
        case (op)
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW,
            OP_PCOUNT:       ex_next = S_M1;
            OP_DIV, OP_DIVU: ex_next = (r_b != 32'd0) ? S_DV : S_FIN;
            default:         ex_next = S_FIN;
        endcase
        case (op)
            OP_J, OP_JAL:   ex_npc = pc4 + r_off;
            OP_JR, OP_JALR: ex_npc = r_a;
            OP_BEQZ:        ex_npc = (r_a == 32'd0) ? (pc4 + r_simm) : pc4;
            OP_BNEZ:        ex_npc = (r_a != 32'd0) ? (pc4 + r_simm) : pc4;
            default:        ex_npc = pc4;
        endcase
    end

    always_comb begin
        case (r_addr[1:0])
            2'd0:    ld_byte = {24'd0, r_mem_q[31:24]};
            2'd1:    ld_byte = {24'd0, r_mem_q[23:16]};
            2'd2:    ld_byte = {24'd0, r_mem_q[15:8]};
            default: ld_byte = {24'd0, r_mem_q[7:0]};
        endcase
        ld_half = r_addr[1] ? {16'd0, r_mem_q[15:0]} : {16'd0, r_mem_q[31:16]};
        st_word = r_mem_q;
        case (op)
            OP_SB: begin
                case (r_addr[1:0])
                    2'd0:    st_word[31:24] = r_b[7:0];
                    2'd1:    st_word[23:16] = r_b[7:0];
                    2'd2:    st_word[15:8]  = r_b[7:0];
                    default: st_word[7:0]   = r_b[7:0];
                endcase
            end
            OP_SH: begin
                if (r_addr[1]) st_word[15:0] = r_b[15:0];
                else           st_word[31:16] = r_b[15:0];
            end
            default: st_word = r_b;
        endcase
    end

    assign cnt_new = r_cnt_q + 32'd1;

    assign clr_mem = ({1'b0, r_clr} < (CLR_AW+1)'(MEM_WORDS));
    assign clr_cnt = ({1'b0, r_clr} < (CLR_AW+1)'(CNT_WORDS));
    assign clr_rf  = ({1'b0, r_clr} < (CLR_AW+1)'(REG_COUNT));

    always_comb begin
        case (r_state)
            S_RA:    rf_raddr = r_rs;
            S_RB:    rf_raddr = r_rt;
            default: rf_raddr = r_rsel;
        endcase
        rf_we    = 1'b0;
        rf_waddr = r_dst;
        rf_wdata = r_val;
        me_we    = 1'b0;
        me_addr  = r_addr[MEM_AW+1:2];
        me_wdata = st_word;
        ce_we    = 1'b0;
        ce_addr  = cidx;
        ce_wdata = cnt_new;
        div_ctl.start = 1'b0;
        div_ctl.sgn   = (op == OP_DIV);
        case (r_state)
            S_CLR: begin
                rf_we    = clr_rf;
                rf_waddr = r_clr[REG_AW-1:0];
                rf_wdata = '0;
                me_we    = clr_mem;
                me_addr  = r_clr[MEM_AW-1:0];
                me_wdata = '0;
                ce_we    = clr_cnt;
                ce_addr  = r_clr[CNT_AW-1:0];
                ce_wdata = '0;
            end
            S_EX: begin
                div_ctl.start = (op == OP_DIV || op == OP_DIVU) && (r_b != 32'd0);
            end
            S_M2: begin
                me_we = (op == OP_SB || op == OP_SH || op == OP_SW);
                ce_we = (op == OP_PCOUNT);
            end
            S_FIN: begin
                rf_we = r_wr && (r_dst != 5'd0);
            end
            S_R25: begin
                rf_we    = 1'b1;
                rf_waddr = REG_REM;
                rf_wdata = r_remv;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[rf_waddr] <= rf_wdata;
        r_rf_q <= r_rf[rf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (me_we) r_mem[me_addr] <= me_wdata;
        r_mem_q <= r_mem[me_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ce_we) r_cmem[ce_addr] <= ce_wdata;
        r_cnt_q <= r_cmem[ce_addr];
    end

    rieu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_done  (div_done),
        .o_quo   (div_q),
        .o_rem   (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_pc     <= '0;
            r_halted <= 1'b0;
            r_hi_cnt <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + CLR_AW'(1);
                    if (r_clr == CLR_AW'(CLR_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= s_axis_tdata[6:0];
                        r_rs     <= s_axis_tdata[11:7];
                        r_rt     <= s_axis_tdata[16:12];
                        r_rd     <= s_axis_tdata[21:17];
                        r_rsel   <= s_axis_tdata[26:22];
                        r_simm   <= {{16{s_axis_tdata[42]}}, s_axis_tdata[42:27]};
                        r_off    <= {{6{s_axis_tdata[68]}}, s_axis_tdata[68:43]};
                        r_status <= r_halted ? ST_HALT : ST_OK;
                        r_npc    <= r_pc;
                        r_wr     <= 1'b0;
                        r_dst    <= '0;
                        r_val    <= '0;
                        r_remw   <= 1'b0;
                        r_remv   <= '0;
                        r_cntv   <= '0;
                        r_state  <= r_halted ? S_OUT : S_RA;
                    end
                end
                S_RA: r_state <= S_RB;
                S_RB: begin
                    r_a     <= r_rf_q;
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_b     <= r_rf_q;
                    r_state <= S_EX;
                end
                S_EX: begin
                    r_npc   <= ex_npc;
                    r_addr  <= r_a + r_simm;
                    r_state <= ex_next;
                    case (op)
                        OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: begin
                            r_wr <= 1'b1; r_dst <= r_rt;
                        end
                        OP_SB, OP_SH, OP_SW, OP_PCOUNT, OP_NOP, OP_J, OP_JR,
                        OP_BEQZ, OP_BNEZ: begin
                        end
                        OP_ADDI: begin r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a + r_simm; end
                        OP_ADDUI: begin r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a + uimm; end
                        OP_SUBI: begin r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a - r_simm; end
                        OP_SUBUI: begin r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a - uimm; end
                        OP_SEQI, OP_SEQUI, OP_SNEI, OP_SNEUI, OP_SLTI, OP_SLTUI, OP_SGTI,
                        OP_SGTUI, OP_SLEI, OP_SLEUI, OP_SGEI, OP_SGEUI: begin
                            r_wr <= 1'b1; r_dst <= r_rt; r_val <= cmp_v;
                        end
                        OP_ANDI: begin r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a & uimm; end
                        OP_ORI: begin r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a | uimm; end
                        OP_XORI: begin r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a ^ uimm; end
                        OP_LHI: begin
                            r_wr <= 1'b1; r_dst <= r_rt; r_val <= {r_simm[15:0], 16'd0};
                        end
                        OP_ADD, OP_ADDU: begin r_wr <= 1'b1; r_dst <= r_rd; r_val <= r_a + r_b; end
                        OP_SUB, OP_SUBU: begin r_wr <= 1'b1; r_dst <= r_rd; r_val <= r_a - r_b; end
                        OP_SEQ, OP_SNE, OP_SLT, OP_SLTU, OP_SGT, OP_SGTU, OP_SLE, OP_SLEU,
                        OP_SGE, OP_SGEU: begin
                            r_wr <= 1'b1; r_dst <= r_rd; r_val <= cmp_v;
                        end
                        OP_AND: begin r_wr <= 1'b1; r_dst <= r_rd; r_val <= r_a & r_b; end
                        OP_OR: begin r_wr <= 1'b1; r_dst <= r_rd; r_val <= r_a | r_b; end
                        OP_XOR: begin r_wr <= 1'b1; r_dst <= r_rd; r_val <= r_a ^ r_b; end
                        OP_SLL: begin r_wr <= 1'b1; r_dst <= r_rd; r_val <= r_b << r_a[4:0]; end
                        OP_SRL: begin r_wr <= 1'b1; r_dst <= r_rd; r_val <= r_b >> r_a[4:0]; end
                        OP_SRA: begin
                            r_wr <= 1'b1; r_dst <= r_rd;
                            r_val <= 32'($signed(r_b) >>> r_a[4:0]);
                        end
                        OP_SLLI: begin
                            r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a << r_simm[4:0];
                        end
                        OP_SRLI: begin
                            r_wr <= 1'b1; r_dst <= r_rt; r_val <= r_a >> r_simm[4:0];
                        end
                        OP_SRAI: begin
                            r_wr <= 1'b1; r_dst <= r_rt;
                            r_val <= 32'($signed(r_a) >>> r_simm[4:0]);
                        end
                        OP_MULT, OP_MULTU: begin
                            r_wr <= 1'b1; r_dst <= r_rd; r_val <= r_a * r_b;
                        end
                        OP_DIV, OP_DIVU: begin
                            if (r_b == 32'd0) r_status <= ST_DIVZ;
                        end
                        OP_JAL: begin
                            r_wr <= 1'b1; r_dst <= REG_LINK; r_val <= pc4;
                        end
                        OP_JALR: begin
                            r_wr <= 1'b1; r_dst <= (r_rd != 5'd0) ? r_rd : REG_LINK;
                            r_val <= pc4;
                        end
                        OP_SELECT: begin
                            r_wr <= 1'b1; r_dst <= r_rd;
                            r_val <= (r_a != 32'd0) ? r_b : r_rf_q;
                        end
                        OP_TRAP, OP_HALT: begin
                            r_status <= ST_HALT; r_halted <= 1'b1;
                        end
                        default: r_status <= ST_UNIMP;
                    endcase
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_state <= S_FIN;
                    case (op)
                        OP_LB:  r_val <= {{24{ld_byte[7]}}, ld_byte[7:0]};
                        OP_LBU: r_val <= ld_byte;
                        OP_LH:  r_val <= {{16{ld_half[15]}}, ld_half[15:0]};
                        OP_LHU: r_val <= ld_half;
                        OP_LW:  r_val <= r_mem_q;
                        OP_PCOUNT: begin
                            r_cntv <= cnt_new;
                            if (cidx > r_hi_cnt) r_hi_cnt <= cidx;
                        end
                        default: begin
                        end
                    endcase
                end
                S_DV: begin
                    if (div_done) begin
                        r_wr    <= 1'b1;
                        r_val   <= div_q;
                        r_dst   <= (r_rd != 5'd0) ? r_rd : REG_QUO;
                        r_remw  <= (r_rd == 5'd0);
                        r_remv  <= (r_rd == 5'd0) ? div_r : 32'd0;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_pc <= r_npc;
                    if (!(r_wr && r_dst != 5'd0)) begin
                        r_wr  <= 1'b0;
                        r_dst <= '0;
                        r_val <= '0;
                    end
                    r_state <= r_remw ? S_R25 : S_OUT;
                end
                S_R25: r_state <= S_OUT;
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {7'd0, r_cntv, r_remv, r_remw, r_val, r_dst, r_wr, r_npc, r_status};

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output both open");
    a_divz_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == ST_DIVZ) |-> (!r_wr && !r_remw))
        else $error("divide by zero wrote a register");
    a_wr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_wr == (r_dst != 5'd0)))
        else $error("write flag and index disagree");
    a_rem_r24: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_remw) |-> (r_dst == REG_QUO))
        else $error("remainder without quotient in r24");
`endif

endmodule

>>> tb/sv/tb_risc_integer_execute_unit_core.sv
// ----------------------------------------------------------------------------
// tb_risc_integer_execute_unit_core
// Self-checking testbench for the integer execute unit. An internal model
// keeps its own register file, data memory, pc, profile counters and halt
// flag. It predicts each result and checks it against the output stream.
// The stimulus is a directed pass, then random instruction mixes with
// random idles on both sides, one long output stall, a back-to-back pass with no idles, and halt at the end.
// ----------------------------------------------------------------------------
module tb_risc_integer_execute_unit_core;
    import rieu_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [6:0]  cmd;
        logic [4:0]  rs, rt, rd, rf;
        logic [15:0] imm;
        logic [25:0] joff;
    } t_instr;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] next_pc;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic        remw;
        logic [31:0] remv;
        logic [31:0] cnt;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // cmd, src_reg, second_reg, dest_reg, select_false_reg, immediate, jump_offset
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // status, next_pc, reg_written, written_index, written_value,
    // remainder_written, remainder_value, counter_value
    logic [OUT_W-1:0]  m_axis_tdata;

    risc_integer_execute_unit_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // model state
    logic [31:0] regs [REG_COUNT];
    logic [31:0] mem [MEM_WORDS];
    logic [31:0] counters [CNT_WORDS];
    logic [31:0] pc;
    logic [9:0]  top_counter;
    logic        halted;

    t_result expected_q [$];
    int errors, sent, checked, idle_cycles;
    bit no_idle, hold_req;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic bit compare_op(logic [6:0] op, logic [31:0] a, logic [31:0] b);
        bit lt, ltu;
        lt  = $signed(a) < $signed(b);
        ltu = a < b;
        case (op)
            OP_SEQI, OP_SEQUI, OP_SEQ: return a == b;
            OP_SNEI, OP_SNEUI, OP_SNE: return a != b;
            OP_SLTI, OP_SLT:           return lt;
            OP_SLTUI, OP_SLTU:         return ltu;
            OP_SGTI, OP_SGT:           return $signed(b) < $signed(a);
            OP_SGTUI, OP_SGTU:         return b < a;
            OP_SLEI, OP_SLE:           return !($signed(b) < $signed(a));
            OP_SLEUI, OP_SLEU:         return !(b < a);
            OP_SGEI, OP_SGE:           return !lt;
            default:                   return !ltu;
        endcase
    endfunction

    task automatic execute(input t_instr it, output t_result r);
        logic [31:0] a, b, imm, off, addr, npc, val, q, rm, ma, mb;
        logic [4:0]  dst;
        logic        wr;
        int          wi, sh;
        logic [9:0]  k;
        r = '{default: '0};
        if (halted) begin
            r.status  = ST_HALT;
            r.next_pc = pc;
            return;
        end
        imm  = {{16{it.imm[15]}}, it.imm};
        off  = {{6{it.joff[25]}}, it.joff};
        a    = regs[it.rs];
        b    = regs[it.rt];
        addr = a + imm;
        wi   = (addr >> 2) % MEM_WORDS;
        npc  = pc + 4;
        dst  = '0;
        val  = '0;
        wr   = 1'b0;
        case (it.cmd)
            OP_LB, OP_LBU: begin
                sh  = (3 - addr[1:0]) * 8;
                val = (mem[wi] >> sh) & 32'hFF;
                if (it.cmd == OP_LB && val[7]) val |= 32'hFFFF_FF00;
                dst = it.rt; wr = 1'b1;
            end
            OP_LH, OP_LHU: begin
                val = addr[1] ? (mem[wi] & 32'hFFFF) : (mem[wi] >> 16);
                if (it.cmd == OP_LH && val[15]) val |= 32'hFFFF_0000;
                dst = it.rt; wr = 1'b1;
            end
            OP_LW: begin val = mem[wi]; dst = it.rt; wr = 1'b1; end
            OP_SB: begin
                sh = (3 - addr[1:0]) * 8;
                mem[wi] = (mem[wi] & ~(32'hFF << sh)) | ((b & 32'hFF) << sh);
            end
            OP_SH: begin
                sh = addr[1] ? 0 : 16;
                mem[wi] = (mem[wi] & ~(32'hFFFF << sh)) | ((b & 32'hFFFF) << sh);
            end
            OP_SW: mem[wi] = b;
            OP_ADDI:  begin val = a + imm; dst = it.rt; wr = 1'b1; end
            OP_ADDUI: begin val = a + {16'h0, it.imm}; dst = it.rt; wr = 1'b1; end
            OP_SUBI:  begin val = a - imm; dst = it.rt; wr = 1'b1; end
            OP_SUBUI: begin val = a - {16'h0, it.imm}; dst = it.rt; wr = 1'b1; end
            OP_SEQI, OP_SEQUI, OP_SNEI, OP_SNEUI, OP_SLTI, OP_SLTUI, OP_SGTI,
            OP_SGTUI, OP_SLEI, OP_SLEUI, OP_SGEI, OP_SGEUI: begin
                val = compare_op(it.cmd, a, imm); dst = it.rt; wr = 1'b1;
            end
            OP_ANDI: begin val = a & {16'h0, it.imm}; dst = it.rt; wr = 1'b1; end
            OP_ORI:  begin val = a | {16'h0, it.imm}; dst = it.rt; wr = 1'b1; end
            OP_XORI: begin val = a ^ {16'h0, it.imm}; dst = it.rt; wr = 1'b1; end
            OP_LHI:  begin val = {it.imm, 16'h0}; dst = it.rt; wr = 1'b1; end
            OP_ADD, OP_ADDU: begin val = a + b; dst = it.rd; wr = 1'b1; end
            OP_SUB, OP_SUBU: begin val = a - b; dst = it.rd; wr = 1'b1; end
            OP_SEQ, OP_SNE, OP_SLT, OP_SLTU, OP_SGT, OP_SGTU, OP_SLE, OP_SLEU,
            OP_SGE, OP_SGEU: begin
                val = compare_op(it.cmd, a, b); dst = it.rd; wr = 1'b1;
            end
            OP_AND: begin val = a & b; dst = it.rd; wr = 1'b1; end
            OP_OR:  begin val = a | b; dst = it.rd; wr = 1'b1; end
            OP_XOR: begin val = a ^ b; dst = it.rd; wr = 1'b1; end
            OP_NOP: ;
            OP_SLL:  begin val = b << a[4:0]; dst = it.rd; wr = 1'b1; end
            OP_SRL:  begin val = b >> a[4:0]; dst = it.rd; wr = 1'b1; end
            OP_SRA:  begin val = $signed(b) >>> a[4:0]; dst = it.rd; wr = 1'b1; end
            OP_SLLI: begin val = a << it.imm[4:0]; dst = it.rt; wr = 1'b1; end
            OP_SRLI: begin val = a >> it.imm[4:0]; dst = it.rt; wr = 1'b1; end
            OP_SRAI: begin val = $signed(a) >>> it.imm[4:0]; dst = it.rt; wr = 1'b1; end
            OP_MULT, OP_MULTU: begin val = a * b; dst = it.rd; wr = 1'b1; end
            OP_DIV, OP_DIVU: begin
                if (b == 0) begin
                    r.status = ST_DIVZ;
                end else begin
                    if (it.cmd == OP_DIV) begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q  = ma / mb;
                        rm = ma % mb;
                        if (a[31] != b[31]) q = -q;
                        if (a[31]) rm = -rm;
                    end else begin
                        q  = a / b;
                        rm = a % b;
                    end
                    val = q; wr = 1'b1;
                    if (it.rd != 0) begin
                        dst = it.rd;
                    end else begin
                        dst = REG_QUO;
                        r.remw = 1'b1;
                        r.remv = rm;
                        regs[REG_REM] = rm;
                    end
                end
            end
            OP_J:    npc = npc + off;
            OP_JAL:  begin dst = REG_LINK; wr = 1'b1; val = npc; npc = npc + off; end
            OP_JR:   npc = a;
            OP_JALR: begin
                dst = (it.rd != 0) ? it.rd : REG_LINK; wr = 1'b1; val = npc; npc = a;
            end
            OP_BEQZ: if (a == 0) npc = npc + imm;
            OP_BNEZ: if (a != 0) npc = npc + imm;
            OP_SELECT: begin val = (a != 0) ? b : regs[it.rf]; dst = it.rd; wr = 1'b1; end
            OP_TRAP, OP_HALT: begin r.status = ST_HALT; halted = 1'b1; end
            OP_PCOUNT: begin
                k = it.imm[9:0];
                counters[k] = counters[k] + 1;
                r.cnt = counters[k];
                if (k > top_counter) top_counter = k;
            end
            default: r.status = ST_UNIMP;
        endcase
        pc = npc;
        r.next_pc = npc;
        if (wr && dst != 0) begin
            regs[dst] = val;
            r.wr = 1'b1; r.widx = dst; r.wval = val;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        errors++;
        $display("mismatch at result %0d: %s got %h expected %h", checked, what, got, exp);
    endtask

    task automatic send_instr(input t_instr it);
        int g;
        t_result r;
        g = $urandom_range(0, 9);
        if (!no_idle && g >= 5) begin
            s_axis_tvalid <= 1'b0;
            repeat (g < 9 ? $urandom_range(1, 3) : $urandom_range(10, 30)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, it.joff, it.imm, it.rf, it.rd, it.rt, it.rs, it.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        execute(it, r);
        expected_q.push_back(r);
        sent++;
    endtask

    function automatic t_instr mk(input logic [6:0] cmd, input logic [4:0] rs, rt, rd,
                                  input logic [15:0] imm);
        t_instr it;
        it.cmd = cmd; it.rs = rs; it.rt = rt; it.rd = rd; it.rf = 5'd0;
        it.imm = imm; it.joff = '0;
        return it;
    endfunction

    function automatic t_instr random_instr();
        t_instr it;
        int r;
        r = $urandom_range(0, 99);
        it.rs = 5'($urandom); it.rt = 5'($urandom); it.rd = 5'($urandom);
        it.rf = 5'($urandom);
        it.imm = 16'($urandom); it.joff = 26'($urandom);
        if (r < 4) begin
            it.cmd = 7'($urandom_range(70, 127));
        end else if (r < 10) begin
            case ($urandom_range(0, 3))
                0: it.cmd = OP_RFE;
                1: it.cmd = OP_BREAK;
                default: it.cmd = OP_PCOUNT;
            endcase
            if ($urandom_range(0, 1)) it.imm = 16'($urandom_range(0, 15));
        end else if (r < 40) begin
            it.cmd = 7'($urandom_range(OP_LB, OP_SW));
            // mostly a small window from r0 so stores are read back
            if ($urandom_range(0, 3) != 0) begin
                it.rs  = 5'd0;
                it.imm = 16'($urandom_range(0, 127));
            end
        end else begin
            it.cmd = 7'($urandom_range(OP_ADDI, OP_SELECT));
        end
        return it;
    endfunction

    task automatic test_directed();
        t_instr it;
        send_instr(mk(OP_LHI, 0, 1, 0, 16'h8000));
        send_instr(mk(OP_ADDI, 0, 2, 0, 16'hFFFF));
        send_instr(mk(OP_DIV, 1, 2, 0, 0));           // overflow into r24/r25
        send_instr(mk(OP_DIV, 2, 0, 3, 0));           // divide by zero
        send_instr(mk(OP_DIVU, 1, 2, 4, 0));
        send_instr(mk(OP_ADDI, 0, 5, 0, 16'h7FFF));
        send_instr(mk(OP_DIV, 2, 5, 0, 0));
        send_instr(mk(OP_SW, 0, 2, 0, 16'd4));
        send_instr(mk(OP_SB, 0, 5, 0, 16'd5));
        send_instr(mk(OP_SH, 0, 1, 0, 16'd6));
        send_instr(mk(OP_LB, 0, 6, 0, 16'd5));
        send_instr(mk(OP_LBU, 0, 7, 0, 16'd4));
        send_instr(mk(OP_LH, 0, 8, 0, 16'd6));
        send_instr(mk(OP_LHU, 0, 9, 0, 16'd5));
        send_instr(mk(OP_ADD, 1, 2, 0, 0));           // write to r0 dropped
        send_instr(mk(OP_MVTS, 0, 0, 0, 0));
        send_instr(mk(OP_MVFS, 0, 0, 0, 0));
        send_instr(mk(7'h7F, 31, 31, 31, 16'hFFFF));
        send_instr(mk(OP_PCOUNT, 0, 0, 0, 16'hFFFF));
        send_instr(mk(OP_PCOUNT, 0, 0, 0, 16'h03FF));
        it = mk(OP_JAL, 0, 0, 0, 0); it.joff = 26'h1FF_FFFF; send_instr(it);
        it = mk(OP_J, 0, 0, 0, 0); it.joff = 26'h200_0000; send_instr(it);
        send_instr(mk(OP_JALR, 5, 0, 0, 0));
        send_instr(mk(OP_BEQZ, 0, 0, 0, 16'h8000));
        it = mk(OP_SELECT, 0, 2, 10, 0); it.rf = 5; send_instr(it);
    endtask

    task automatic test_random(input int n);
        repeat (n) send_instr(random_instr());
    endtask

    task automatic test_output_stall();
        hold_req = 1'b1;
        test_random(40);
    endtask

    task automatic test_back_to_back(input int n);
        no_idle = 1'b1;
        test_random(n);
        no_idle = 1'b0;
    endtask

    task automatic test_halt();
        send_instr(mk(OP_TRAP, 0, 0, 0, 0));
        send_instr(mk(OP_HALT, 0, 0, 0, 0));
        send_instr(mk(OP_ADDI, 0, 3, 0, 16'h1234));
        send_instr(mk(OP_PCOUNT, 0, 0, 0, 16'h1));
    endtask

    // output side: random back-pressure and one long hold
    initial begin
        int r;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                if (no_idle || r < 6) begin
                    m_axis_tready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (r < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40))
                        @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("unexpected result %h", m_axis_tdata);
            end else begin
                e = expected_q.pop_front();
                if (m_axis_tdata[1:0] != e.status) report("status", m_axis_tdata[1:0], e.status);
                if (m_axis_tdata[33:2] != e.next_pc) report("next_pc", m_axis_tdata[33:2], e.next_pc);
                if (m_axis_tdata[34] != e.wr) report("reg_written", m_axis_tdata[34], e.wr);
                if (m_axis_tdata[39:35] != e.widx) report("written_index", m_axis_tdata[39:35], e.widx);
                if (m_axis_tdata[71:40] != e.wval) report("written_value", m_axis_tdata[71:40], e.wval);
                if (m_axis_tdata[72] != e.remw) report("remainder_written", m_axis_tdata[72], e.remw);
                if (m_axis_tdata[104:73] != e.remv) report("remainder_value", m_axis_tdata[104:73], e.remv);
                if (m_axis_tdata[136:105] != e.cnt) report("counter_value", m_axis_tdata[136:105], e.cnt);
            end
            checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (regs[i]) regs[i] = '0;
        foreach (mem[i]) mem[i] = '0;
        foreach (counters[i]) counters[i] = '0;
        pc = '0; top_counter = '0; halted = 1'b0;
        errors = 0; sent = 0; checked = 0; idle_cycles = 0;
        no_idle = 1'b0; hold_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(600);
        test_output_stall();
        test_back_to_back(300);
        test_random(760);
        test_halt();
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("sent %0d instructions, checked %0d results", sent, checked);
        $display("loads/stores, ALU, divide, jumps, branches, pcount, undefined codes, halt");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> risc_integer_execute_unit_core.f
rtl/rieu_pkg.sv
rtl/rieu_div.sv
rtl/risc_integer_execute_unit_core.sv
tb/sv/tb_risc_integer_execute_unit_core.sv
